FILE: hdl/rotate_point_about_pivot_top_macros.svh
// Assertion macros for the rotate_point_about_pivot block.
// Used by the port checker; depends on nothing else.
`ifndef ROTATE_POINT_ABOUT_PIVOT_TOP_MACROS_SVH
`define ROTATE_POINT_ABOUT_PIVOT_TOP_MACROS_SVH

// implication in the same cycle, off during reset
`define RPP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication into the next cycle, off during reset
`define RPP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication that also holds through reset
`define RPP_ASSERT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/rpp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the point rotation pipeline.
// No dependencies; used by every module of the block.
package rpp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int CW    = 32;  // coordinate width, Q16.16
  localparam int AW    = 20;  // angle port width
  localparam int VW    = 33;  // point minus pivot
  localparam int GUARD = 8;   // extra fraction bits in the rotator
  localparam int XW    = 43;  // rotator x/y width
  localparam int ZFW   = 35;  // folded angle width, Q32
  localparam int KW    = 30;  // gain fraction bits
  localparam int TBL   = 32;

  localparam logic [35:0] PI_Q32      = 36'h3243F6A89;
  localparam logic [35:0] HALF_PI_Q32 = 36'h1921FB544;
  localparam logic [35:0] TWO_PI_Q32  = 36'h6487ED511;

  localparam logic signed [CW-1:0] SAT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0] SAT_MIN = -32'sh7FFFFFFF - 32'sd1;

  // atan(2^-i), Q32
  localparam logic [31:0] ATAN_TAB [TBL] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0]  vx;
    logic signed [VW-1:0]  vy;
    logic signed [ZFW-1:0] z;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
  } red_t;

  typedef struct packed {
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZFW-1:0] z;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
  } cord_t;

  // Q30 gain: round(2^60 / floor(sqrt(prod(1 + 4^-i)))), elaboration only
  function automatic logic [KW-1:0] cordic_gain(input int stages);
    longint unsigned prod;
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    longint unsigned num;
    longint unsigned rem;
    longint unsigned q;
    prod = 64'd1 << 60;
    for (int i = 0; i < TBL; i++) begin
      if (i < stages) begin
        prod = prod + (prod >> (2 * i));
      end
    end
    n = prod;
    r = 64'd0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'd1 << (2 * k);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    num = (64'd1 << 60) + (r >> 1);
    rem = 64'd0;
    q   = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 1) | ((num >> k) & 64'd1);
      if (rem >= r) begin
        rem = rem - r;
        q   = q | (64'd1 << k);
      end
    end
    return q[KW-1:0];
  endfunction

endpackage

FILE: hdl/rpp_reduce.sv
`timescale 1ns / 1ps
// Front of the pipeline: point minus pivot, angle reduction by 2*pi and fold
// into +-pi/2. Depends on rpp_pkg.
module rpp_reduce #(
  parameter int FRAC_BITS = rpp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [rpp_pkg::CW-1:0]   point_x,
  input  logic signed [rpp_pkg::CW-1:0]   point_y,
  input  logic signed [rpp_pkg::CW-1:0]   pivot_x,
  input  logic signed [rpp_pkg::CW-1:0]   pivot_y,
  input  logic signed [rpp_pkg::AW-1:0]   angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rpp_pkg::red_t                   out_item
);
  import rpp_pkg::*;

  localparam int RS  = (FRAC_BITS < 16) ? 17 - FRAC_BITS : 1;
  localparam int NS  = RS + 3;
  localparam int ZW  = (54 - FRAC_BITS > 37) ? 54 - FRAC_BITS : 37;
  localparam int ZSH = 32 - FRAC_BITS;

  localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q32);
  localparam logic signed [ZW-1:0] NPI_Z   = -PI_Z;
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(HALF_PI_Q32);
  localparam logic signed [ZW-1:0] NHALF_Z = -HALF_Z;
  localparam logic signed [ZW-1:0] TWO_Z   = ZW'(TWO_PI_Q32);

  logic                 vld [NS];
  logic                 rdy [NS+1];
  vec_t                 vec [NS-1];
  logic signed [ZW-1:0] zs  [NS-1];
  red_t                 fold;
  red_t                 fold_next;
  logic signed [ZW-1:0] fin_d;
  logic                 fin_take;
  logic signed [ZW-1:0] zf;
  logic                 flip;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      vec[0].vx <= VW'(point_x) - VW'(pivot_x);
      vec[0].vy <= VW'(point_y) - VW'(pivot_y);
      vec[0].px <= pivot_x;
      vec[0].py <= pivot_y;
      zs[0]     <= ZW'(angle) <<< ZSH;
    end
  end

  // binary search for the count of 2*pi steps, one bit per stage
  for (genvar k = 1; k <= RS; k++) begin : g_red
    localparam logic signed [ZW-1:0] STEP = TWO_Z <<< (RS - k);
    logic signed [ZW-1:0] d;
    logic                 take;

    always_comb begin
      if (!zs[k-1][ZW-1]) begin
        d    = zs[k-1] - STEP;
        take = d > PI_Z;
      end else begin
        d    = zs[k-1] + STEP;
        take = d < NPI_Z;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        vec[k] <= vec[k-1];
        zs[k]  <= take ? d : zs[k-1];
      end
    end
  end

  // last single step of 2*pi
  always_comb begin
    if (!zs[RS][ZW-1]) begin
      fin_d    = zs[RS] - TWO_Z;
      fin_take = zs[RS] > PI_Z;
    end else begin
      fin_d    = zs[RS] + TWO_Z;
      fin_take = zs[RS] < NPI_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[RS+1] && vld[RS]) begin
      vec[RS+1] <= vec[RS];
      zs[RS+1]  <= fin_take ? fin_d : zs[RS];
    end
  end

  // fold into +-pi/2, negating the vector
  always_comb begin
    priority if (zs[RS+1] > HALF_Z) begin
      zf   = zs[RS+1] - PI_Z;
      flip = 1'b1;
    end else if (zs[RS+1] < NHALF_Z) begin
      zf   = zs[RS+1] + PI_Z;
      flip = 1'b1;
    end else begin
      zf   = zs[RS+1];
      flip = 1'b0;
    end
    fold_next.vx = flip ? -vec[RS+1].vx : vec[RS+1].vx;
    fold_next.vy = flip ? -vec[RS+1].vy : vec[RS+1].vy;
    fold_next.z  = ZFW'(zf);
    fold_next.px = vec[RS+1].px;
    fold_next.py = vec[RS+1].py;
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1] && vld[NS-2]) begin
      fold <= fold_next;
    end
  end

  assign out_valid = vld[NS-1];
  assign out_item  = fold;

endmodule

FILE: hdl/rpp_cordic.sv
`timescale 1ns / 1ps
// Gain multiply followed by one register stage per CORDIC iteration.
// Depends on rpp_pkg.
module rpp_cordic #(
  parameter int CORDIC_STAGES = rpp_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpp_pkg::red_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output rpp_pkg::cord_t out_item
);
  import rpp_pkg::*;

  localparam int NS = CORDIC_STAGES + 1;
  localparam int PW = VW + KW + 1;
  localparam logic signed [KW:0] GAIN = {1'b0, cordic_gain(CORDIC_STAGES)};

  logic                 vld [NS];
  logic                 rdy [NS+1];
  cord_t                cs  [NS];
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    prod_x = in_item.vx * GAIN;
    prod_y = in_item.vy * GAIN;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      cs[0].x  <= XW'(prod_x >>> (KW - GUARD));
      cs[0].y  <= XW'(prod_y >>> (KW - GUARD));
      cs[0].z  <= in_item.z;
      cs[0].px <= in_item.px;
      cs[0].py <= in_item.py;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_iter
    localparam logic signed [ZFW-1:0] AT = ZFW'(ATAN_TAB[k-1]);
    cord_t nxt;

    always_comb begin
      nxt = cs[k-1];
      if (!cs[k-1].z[ZFW-1]) begin
        nxt.x = cs[k-1].x - (cs[k-1].y >>> (k - 1));
        nxt.y = cs[k-1].y + (cs[k-1].x >>> (k - 1));
        nxt.z = cs[k-1].z - AT;
      end else begin
        nxt.x = cs[k-1].x + (cs[k-1].y >>> (k - 1));
        nxt.y = cs[k-1].y - (cs[k-1].x >>> (k - 1));
        nxt.z = cs[k-1].z + AT;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        cs[k] <= nxt;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_item  = cs[NS-1];

endmodule

FILE: hdl/rpp_post.sv
`timescale 1ns / 1ps
// Back of the pipeline: drop guard bits with rounding, add the pivot back,
// saturate to 32 bits. Holds the output register. Depends on rpp_pkg.
module rpp_post (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rpp_pkg::cord_t                in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [rpp_pkg::CW-1:0] out_x,
  output logic signed [rpp_pkg::CW-1:0] out_y,
  output logic                          saturated
);
  import rpp_pkg::*;

  localparam int RW = XW - GUARD;
  localparam int SW = RW + 1;
  localparam logic signed [XW-1:0] RND  = XW'(1) <<< (GUARD - 1);
  localparam logic signed [SW-1:0] MAXW = SW'(SAT_MAX);
  localparam logic signed [SW-1:0] MINW = SW'(SAT_MIN);

  logic                 vld [2];
  logic                 rdy [3];
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [CW-1:0] out_x_next;
  logic signed [CW-1:0] out_y_next;
  logic                 fx;
  logic                 fy;

  assign rdy[2]   = out_ready;
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
      vld[1] <= 1'b0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  always_comb begin
    xr = in_item.x + RND;
    yr = in_item.y + RND;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rx <= RW'(xr >>> GUARD);
      ry <= RW'(yr >>> GUARD);
      px <= in_item.px;
      py <= in_item.py;
    end
  end

  always_comb begin
    sx = SW'(rx) + SW'(px);
    sy = SW'(ry) + SW'(py);
    priority if (sx > MAXW) begin
      out_x_next = SAT_MAX;
      fx         = 1'b1;
    end else if (sx < MINW) begin
      out_x_next = SAT_MIN;
      fx         = 1'b1;
    end else begin
      out_x_next = CW'(sx);
      fx         = 1'b0;
    end
    priority if (sy > MAXW) begin
      out_y_next = SAT_MAX;
      fy         = 1'b1;
    end else if (sy < MINW) begin
      out_y_next = SAT_MIN;
      fy         = 1'b1;
    end else begin
      out_y_next = CW'(sy);
      fy         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      out_x     <= out_x_next;
      out_y     <= out_y_next;
      saturated <= fx || fy;
    end
  end

  assign out_valid = vld[1];

endmodule

FILE: hdl/rotate_point_about_pivot_top.sv
`timescale 1ns / 1ps
// Rotation of a point about a pivot by a CORDIC pipeline, one item per cycle
// while out_ready is high. Stages: input register, 2*pi reduction search (one
// bit per stage), last 2*pi step, fold, gain multiplier, one stage per CORDIC
// iteration, then rounding and output registers. Ready is a combinational
// chain back through the stages, so bubbles are squeezed out while the output
// stalls. No state is kept between items and no clearing is needed after
// reset. Depends on rpp_pkg, rpp_reduce, rpp_cordic and rpp_post.
module rotate_point_about_pivot_top #(
  parameter int CORDIC_STAGES = rpp_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = rpp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [rpp_pkg::CW-1:0] point_x,
  input  logic signed [rpp_pkg::CW-1:0] point_y,
  input  logic signed [rpp_pkg::CW-1:0] pivot_x,
  input  logic signed [rpp_pkg::CW-1:0] pivot_y,
  input  logic signed [rpp_pkg::AW-1:0] angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [rpp_pkg::CW-1:0] out_x,
  output logic signed [rpp_pkg::CW-1:0] out_y,
  output logic                          saturated
);
  import rpp_pkg::*;

  red_t  red_item;
  logic  red_valid;
  logic  red_ready;
  cord_t cord_item;
  logic  cord_valid;
  logic  cord_ready;

  rpp_reduce #(
    .FRAC_BITS(FRAC_BITS)
  ) u_reduce (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .point_x  (point_x),
    .point_y  (point_y),
    .pivot_x  (pivot_x),
    .pivot_y  (pivot_y),
    .angle    (angle),
    .out_valid(red_valid),
    .out_ready(red_ready),
    .out_item (red_item)
  );

  rpp_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (red_valid),
    .in_ready (red_ready),
    .in_item  (red_item),
    .out_valid(cord_valid),
    .out_ready(cord_ready),
    .out_item (cord_item)
  );

  rpp_post u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cord_valid),
    .in_ready (cord_ready),
    .in_item  (cord_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x    (out_x),
    .out_y    (out_y),
    .saturated(saturated)
  );

endmodule

FILE: hdl/rpp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for rotate_point_about_pivot_top, bound to it below.
// Depends on rpp_pkg and rotate_point_about_pivot_top_macros.svh.
`include "rotate_point_about_pivot_top_macros.svh"

module rpp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [rpp_pkg::CW-1:0] out_x,
  input logic signed [rpp_pkg::CW-1:0] out_y,
  input logic                          saturated
);
  import rpp_pkg::*;

  `RPP_ASSERT_ALL(a_reset_idle, clk, $past(rst), !out_valid, "item out right after reset")
  `RPP_ASSERT_IMP(a_ready_flow, clk, rst, out_ready, in_ready, "input blocked with output open")
  `RPP_ASSERT_IMP(a_sat_clip, clk, rst, out_valid && saturated, (out_x == SAT_MAX) || (out_x == SAT_MIN) || (out_y == SAT_MAX) || (out_y == SAT_MIN), "saturated without a clipped value")
  `RPP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(saturated), "stalled item changed")

endmodule

bind rotate_point_about_pivot_top rpp_checker u_rpp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_x    (out_x),
  .out_y    (out_y),
  .saturated(saturated)
);

FILE: dv/rotation_checker.sv
`timescale 1ns / 1ps
// Scoreboard for rotate_point_about_pivot_top: predicts each rotated point from
// the accepted input items and compares the results in order.
// Depends on rpp_pkg for port widths and the default parameters.
module rotation_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [rpp_pkg::CW-1:0] point_x,
  input  logic signed [rpp_pkg::CW-1:0] point_y,
  input  logic signed [rpp_pkg::CW-1:0] pivot_x,
  input  logic signed [rpp_pkg::CW-1:0] pivot_y,
  input  logic signed [rpp_pkg::AW-1:0] angle,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [rpp_pkg::CW-1:0] out_x,
  input  logic signed [rpp_pkg::CW-1:0] out_y,
  input  logic                          saturated,
  output int                            mismatches,
  output int                            pending
);

  localparam int STAGES   = rpp_pkg::CORDIC_STAGES_DEF;
  localparam int ANG_FRAC = rpp_pkg::FRAC_BITS_DEF;
  localparam int EXTRA    = 8;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } rotated_point_t;

  rotated_point_t expected_points[$];

  longint pi_q32;
  longint half_pi_q32;
  longint two_pi_q32;
  longint gain_q30;
  longint arctan_q32 [32];

  // atan(1/n) in Q60 by its power series
  function automatic longint unsigned arctan_recip_q60(input longint unsigned n);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned k;
    p   = (64'd1 << 60) / n;
    acc = 64'd0;
    k   = 64'd0;
    while (p != 0) begin
      if (k[0]) acc = acc - p / (64'd2 * k + 64'd1);
      else acc = acc + p / (64'd2 * k + 64'd1);
      p = p / (n * n);
      k = k + 64'd1;
    end
    return acc;
  endfunction

  function automatic longint unsigned isqrt_u64(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    longint unsigned pi60;
    longint unsigned prod;
    longint unsigned p;
    longint unsigned acc;
    longint unsigned k;
    longint unsigned root;
    pi60 = 64'd4 * (64'd4 * arctan_recip_q60(64'd5) - arctan_recip_q60(64'd239));
    pi_q32      = longint'((pi60 + (64'd1 << 27)) >> 28);
    half_pi_q32 = longint'((pi60 + (64'd1 << 28)) >> 29);
    two_pi_q32  = longint'((pi60 + (64'd1 << 26)) >> 27);
    arctan_q32[0] = longint'(((pi60 >> 2) + (64'd1 << 27)) >> 28);
    for (int i = 1; i < 32; i++) begin
      p   = 64'd1 << (60 - i);
      acc = 64'd0;
      k   = 64'd0;
      while (p != 0) begin
        if (k[0]) acc = acc - p / (64'd2 * k + 64'd1);
        else acc = acc + p / (64'd2 * k + 64'd1);
        p = p >> (2 * i);
        k = k + 64'd1;
      end
      arctan_q32[i] = longint'((acc + (64'd1 << 27)) >> 28);
    end
    prod = 64'd1 << 60;
    for (int i = 0; i < STAGES && i < 32; i++) prod = prod + (prod >> (2 * i));
    root = isqrt_u64(prod);
    gain_q30 = longint'(((64'd1 << 60) + (root >> 1)) / root);
    mismatches = 0;
    pending    = 0;
  end

  function automatic rotated_point_t rotate_about_pivot(
    input logic signed [31:0] ptx,
    input logic signed [31:0] pty,
    input logic signed [31:0] pvx,
    input logic signed [31:0] pvy,
    input logic signed [19:0] ang
  );
    rotated_point_t r;
    longint vx;
    longint vy;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint ox;
    longint oy;
    vx = longint'(ptx) - longint'(pvx);
    vy = longint'(pty) - longint'(pvy);
    z  = longint'(ang) <<< (32 - ANG_FRAC);
    while (z > pi_q32) z = z - two_pi_q32;
    while (z < -pi_q32) z = z + two_pi_q32;
    if (z > half_pi_q32) begin
      z  = z - pi_q32;
      vx = -vx;
      vy = -vy;
    end else if (z < -half_pi_q32) begin
      z  = z + pi_q32;
      vx = -vx;
      vy = -vy;
    end
    x = (vx * gain_q30) >>> (30 - EXTRA);
    y = (vy * gain_q30) >>> (30 - EXTRA);
    for (int i = 0; i < STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q32[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q32[i];
      end
    end
    ox = ((x + (64'sd1 <<< (EXTRA - 1))) >>> EXTRA) + longint'(pvx);
    oy = ((y + (64'sd1 <<< (EXTRA - 1))) >>> EXTRA) + longint'(pvy);
    r.sat = 1'b0;
    if (ox > COORD_MAX) begin ox = COORD_MAX; r.sat = 1'b1; end
    if (ox < COORD_MIN) begin ox = COORD_MIN; r.sat = 1'b1; end
    if (oy > COORD_MAX) begin oy = COORD_MAX; r.sat = 1'b1; end
    if (oy < COORD_MIN) begin oy = COORD_MIN; r.sat = 1'b1; end
    r.x = ox[31:0];
    r.y = oy[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    rotated_point_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_points.push_back(rotate_about_pivot(point_x, point_y, pivot_x, pivot_y, angle));
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("result with no item pending", out_x, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

FILE: dv/tb_rotate_point_about_pivot_top.sv
`timescale 1ns / 1ps
// Testbench top for rotate_point_about_pivot_top: clock, reset, directed and
// random point items with bursty input and stalling output, and the verdict.
// Depends on rpp_pkg, the block under test and rotation_checker.
module tb_rotate_point_about_pivot_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [31:0] C_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE   = 32'sh00010000;

  // angles in Q3.16 radians, codes next to the fold and wrap points and the range ends
  localparam int ANG_HALF_PI = 102943;
  localparam int ANG_PI      = 205887;
  localparam int ANG_TWO_PI  = 411775;
  localparam int ANG_MAX     = 524287;
  localparam int ANG_MIN     = -524288;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [rpp_pkg::CW-1:0] point_x;
  logic signed [rpp_pkg::CW-1:0] point_y;
  logic signed [rpp_pkg::CW-1:0] pivot_x;
  logic signed [rpp_pkg::CW-1:0] pivot_y;
  logic signed [rpp_pkg::AW-1:0] angle;
  logic out_valid;
  logic out_ready;
  logic signed [rpp_pkg::CW-1:0] out_x;
  logic signed [rpp_pkg::CW-1:0] out_y;
  logic saturated;
  int mismatches;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  bit quiet = 1'b0;

  always #10 clk = ~clk;

  rotate_point_about_pivot_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .pivot_x(pivot_x), .pivot_y(pivot_y),
    .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .saturated(saturated)
  );

  rotation_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .pivot_x(pivot_x), .pivot_y(pivot_y),
    .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .saturated(saturated),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rotate_point_about_pivot_top");
      $finish;
    end
  end

  // output stall pattern: always ready, random drops, or long stalls
  always @(negedge clk) begin
    int rx_mode;
    int rx_left;
    int stall_left;
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(64, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  task automatic send_item(input logic signed [31:0] ax, input logic signed [31:0] ay,
                           input logic signed [31:0] bx, input logic signed [31:0] by,
                           input logic signed [19:0] ang);
    point_x  <= ax;
    point_y  <= ay;
    pivot_x  <= bx;
    pivot_y  <= by;
    angle    <= ang;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      if (!quiet) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        in_valid <= 1'b0;
        point_x  <= $urandom;
        angle    <= 20'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_paced(input logic signed [31:0] ax, input logic signed [31:0] ay,
                            input logic signed [31:0] bx, input logic signed [31:0] by,
                            input int ang);
    send_item(ax, ay, bx, by, 20'(ang));
    pace_sender();
  endtask

  function automatic logic signed [31:0] pick_coord();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: v = int'($urandom_range(0, 8388608)) - 4194304;
    endcase
    return v;
  endfunction

  function automatic logic signed [19:0] pick_angle();
    int a;
    case ($urandom_range(0, 7))
      0: a = $urandom;
      1: a = ANG_PI + int'($urandom_range(0, 6)) - 3;
      2: a = ANG_HALF_PI + int'($urandom_range(0, 6)) - 3;
      3: begin
        case ($urandom_range(0, 2))
          0: a = ANG_TWO_PI + int'($urandom_range(0, 6)) - 3;
          1: a = ANG_MAX - int'($urandom_range(0, 3));
          default: a = int'($urandom_range(0, 8)) - 4;
        endcase
      end
      default: a = int'($urandom_range(0, 2 * ANG_PI)) - ANG_PI;
    endcase
    if (a != ANG_MIN && $urandom_range(0, 1) == 1) a = -a;
    return a[19:0];
  endfunction

  initial begin
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    rst       = 1'b1;
    in_valid  = 1'b0;
    point_x   = '0;
    point_y   = '0;
    pivot_x   = '0;
    pivot_y   = '0;
    angle     = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_paced(0, 0, 0, 0, 0);
    send_paced(ONE, 0, 0, 0, ANG_HALF_PI);
    send_paced(ONE, 0, 0, 0, ANG_HALF_PI + 1);
    send_paced(0, ONE, 0, 0, -ANG_HALF_PI);
    send_paced(0, ONE, 0, 0, -ANG_HALF_PI - 1);
    send_paced(ONE, ONE, 0, 0, ANG_PI);
    send_paced(ONE, ONE, 0, 0, ANG_PI + 1);
    send_paced(ONE, -ONE, ONE, 0, -ANG_PI);
    send_paced(ONE, -ONE, ONE, 0, -ANG_PI - 1);
    send_paced(3 * ONE, 5 * ONE, -ONE, 2 * ONE, ANG_MAX);
    send_paced(3 * ONE, 5 * ONE, -ONE, 2 * ONE, ANG_MIN);
    send_paced(7 * ONE, -2 * ONE, ONE, ONE, ANG_TWO_PI);
    send_paced(7 * ONE, -2 * ONE, ONE, ONE, -ANG_TWO_PI);
    // largest vectors, saturating both ways
    send_paced(C_MAX, C_MAX, C_MIN, C_MIN, 0);
    send_paced(C_MIN, C_MIN, C_MAX, C_MAX, 0);
    send_paced(C_MAX, C_MIN, C_MIN, C_MAX, ANG_HALF_PI);
    send_paced(C_MAX, C_MAX, 0, 0, ANG_PI);
    send_paced(C_MIN, C_MIN, 0, 0, ANG_PI);
    // zero vectors, mostly at the pivot extremes, then a unit vector near the top edge
    send_paced(C_MAX, C_MIN, C_MAX, C_MIN, ANG_PI);
    send_paced(C_MIN, C_MAX, C_MIN, C_MAX, ANG_MIN);
    send_paced(-1, -1, -1, -1, -1);
    send_paced(C_MAX, 0, C_MAX - ONE, 0, ANG_HALF_PI);
    drain_pipeline();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_ITEMS / 2) drain_pipeline();
      ax = pick_coord();
      ay = pick_coord();
      if ($urandom_range(0, 3) == 0) begin
        bx = ax + int'($urandom_range(0, 2097152)) - 1048576;
        by = ay + int'($urandom_range(0, 2097152)) - 1048576;
      end else begin
        bx = pick_coord();
        by = pick_coord();
      end
      send_paced(ax, ay, bx, by, pick_angle());
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS rotate_point_about_pivot_top");
    end else begin
      $display("FAIL rotate_point_about_pivot_top");
    end
    $finish;
  end

endmodule
